// ===== sv/crc16fc_pkg.sv =====
// Shared types, constants and the byte-wide CRC-16/MODBUS update for the frame checker.
package crc16fc_pkg;

    localparam int LEN_WIDTH_DEF = 16;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Bytes of a frame that are not payload: header, five header fields,
    // two length bytes, two CRC bytes and the trailer.
    localparam int FRAME_OVERHEAD = 11;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 64;
    localparam int RES_W       = 58;

    localparam int NUM_FIELDS = 5;
    localparam int DLY_DEPTH  = 3;

    // Configuration register indexes.
    localparam logic CFG_HEADER  = 1'b0;
    localparam logic CFG_TRAILER = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FORMAT = 2'd1,
        ST_CRC    = 2'd2
    } t_status;

    typedef struct packed {
        logic       we;
        logic       index;
        logic [7:0] data;
    } t_cfg_wr;

    // Packed so that status sits in the lowest bits.
    typedef struct packed {
        logic [15:0] payload_len;
        logic [7:0]  seq_number;
        logic [7:0]  flag_bits;
        logic [7:0]  command;
        logic [7:0]  src_addr;
        logic [7:0]  dst_addr;
        t_status     status;
    } t_result;

    // One byte through the reflected CRC, eight bit steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== sv/crc16fc_in_reg.sv =====
// Input register stage that holds one accepted byte until the frame logic takes it.
module crc16fc_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_advance,
    output logic       o_ready,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_last
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       r_last;

    assign o_ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
            r_last <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

// ===== sv/crc16fc_frame.sv =====
// Frame state, running CRC, delay line and the end-of-frame checks.
module crc16fc_frame #(
    parameter int LEN_WIDTH = crc16fc_pkg::LEN_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  crc16fc_pkg::t_cfg_wr i_cfg,
    input  logic                 i_advance,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output logic                 o_res_valid,
    output crc16fc_pkg::t_result o_res
);

    localparam logic [15:0] LenMask16 = 16'((32'd1 << LEN_WIDTH) - 1);
    localparam logic [LEN_WIDTH-1:0] Overhead = LEN_WIDTH'(crc16fc_pkg::FRAME_OVERHEAD);

    logic [7:0]           r_header_byte;
    logic [7:0]           r_trailer_byte;

    logic [LEN_WIDTH-1:0] r_count;
    logic [LEN_WIDTH-1:0] n_count;
    logic [15:0]          r_crc;
    logic [15:0]          n_crc;
    logic [7:0]           r_dly [crc16fc_pkg::DLY_DEPTH];
    logic                 r_hdr_ok;
    logic                 n_hdr_ok;
    logic [7:0]           r_fields [crc16fc_pkg::NUM_FIELDS];
    logic [7:0]           n_fields [crc16fc_pkg::NUM_FIELDS];
    logic [15:0]          r_len;
    logic [15:0]          n_len;

    logic [LEN_WIDTH-1:0] total;
    logic [LEN_WIDTH-1:0] expect_total;
    logic [15:0]          recv_crc;
    logic                 count_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_byte  <= 8'h00;
            r_trailer_byte <= 8'h00;
        end else if (i_cfg.we) begin
            unique case (i_cfg.index)
                crc16fc_pkg::CFG_HEADER:  r_header_byte  <= i_cfg.data;
                crc16fc_pkg::CFG_TRAILER: r_trailer_byte <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign count_sat = (r_count == '1);

    always_comb begin
        n_hdr_ok = r_hdr_ok;
        if (r_count == '0) begin
            n_hdr_ok = (i_byte == r_header_byte);
        end
        for (int i = 0; i < crc16fc_pkg::NUM_FIELDS; i++) begin
            n_fields[i] = (r_count == LEN_WIDTH'(i + 1)) ? i_byte : r_fields[i];
        end
        n_len = r_len;
        if (r_count == LEN_WIDTH'(6)) begin
            n_len = {i_byte, 8'h00};
        end else if (r_count == LEN_WIDTH'(7)) begin
            n_len = {r_len[15:8], i_byte};
        end
        // The oldest delayed byte enters the CRC once it is past the header byte.
        n_crc = (r_count >= LEN_WIDTH'(4)) ? crc16fc_pkg::crc_byte(r_crc, r_dly[2]) : r_crc;
        n_count = count_sat ? r_count : r_count + LEN_WIDTH'(1);
    end

    assign total        = n_count;
    assign expect_total = n_len[LEN_WIDTH-1:0] + Overhead;
    assign recv_crc     = {r_dly[0], r_dly[1]};

    always_comb begin
        o_res.dst_addr    = n_fields[0];
        o_res.src_addr    = n_fields[1];
        o_res.command     = n_fields[2];
        o_res.flag_bits   = n_fields[3];
        o_res.seq_number  = n_fields[4];
        o_res.payload_len = n_len & LenMask16;
        priority if (total < Overhead || !n_hdr_ok || i_byte != r_trailer_byte) begin
            o_res.status = crc16fc_pkg::ST_FORMAT;
        end else if (total != expect_total) begin
            o_res.status = crc16fc_pkg::ST_FORMAT;
        end else if (n_crc != recv_crc) begin
            o_res.status = crc16fc_pkg::ST_CRC;
        end else begin
            o_res.status = crc16fc_pkg::ST_OK;
        end
    end

    assign o_res_valid = i_advance && i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_last)) begin
            r_count  <= '0;
            r_crc    <= crc16fc_pkg::CRC_INIT;
            r_hdr_ok <= 1'b0;
            r_len    <= 16'h0000;
            for (int i = 0; i < crc16fc_pkg::DLY_DEPTH; i++) begin
                r_dly[i] <= 8'h00;
            end
            for (int i = 0; i < crc16fc_pkg::NUM_FIELDS; i++) begin
                r_fields[i] <= 8'h00;
            end
        end else if (i_advance) begin
            r_count  <= n_count;
            r_crc    <= n_crc;
            r_hdr_ok <= n_hdr_ok;
            r_len    <= n_len;
            r_dly[2] <= r_dly[1];
            r_dly[1] <= r_dly[0];
            r_dly[0] <= i_byte;
            for (int i = 0; i < crc16fc_pkg::NUM_FIELDS; i++) begin
                r_fields[i] <= n_fields[i];
            end
        end
    end

endmodule

// ===== sv/crc16fc_out_reg.sv =====
// Result register that holds one frame report until the downstream side takes it.
module crc16fc_out_reg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  crc16fc_pkg::t_result                i_res,
    input  logic                                i_ready,
    output logic                                o_space,
    output logic                                o_valid,
    output logic [crc16fc_pkg::OUT_TDATA_W-1:0] o_data
);

    logic                 r_valid;
    logic                 n_valid;
    crc16fc_pkg::t_result r_res;

    assign o_space = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = crc16fc_pkg::OUT_TDATA_W'(r_res);

endmodule

// ===== sv/crc16_frame_checker_core.sv =====
// Top level of the CRC-16/MODBUS frame checker: input stage, frame logic, result register.
// A last byte is registered in the input register, and its report in the result register.
// Throughput: one byte beat per cycle; the input register, one pass of frame logic with a
// byte-wide unrolled CRC and the result register let beats follow each other back to back.
// A last beat waits in the input register only while an earlier report is still not taken.
// Reset (i_rst_n low at a clock edge) empties both registers and clears the frame state and the
// header and trailer configuration bytes to zero.
module crc16_frame_checker_core #(
    parameter int LEN_WIDTH = crc16fc_pkg::LEN_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration: index 0 header byte, index 1 trailer byte.
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [7:0]                          i_cfg_data,
    // Byte stream in.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: [7:0] frame_byte
    input  logic [crc16fc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tlast: last_byte
    input  logic                                s_axis_tlast,
    // Frame reports out.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: [1:0] status, [9:2] dst_addr, [17:10] src_addr, [25:18] command,
    // [33:26] flag_bits, [41:34] seq_number, [57:42] payload_len, [63:58] zero
    output logic [crc16fc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    crc16fc_pkg::t_cfg_wr cfg;
    crc16fc_pkg::t_result res;

    logic       in_valid;
    logic [7:0] in_byte;
    logic       in_last;
    logic       advance;
    logic       out_space;
    logic       res_valid;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    // A byte held in the input register moves through the frame logic when it advances.
    // Only a last byte produces a report, so only a last byte has to wait for room in
    // the result register; every other byte advances at once.
    assign advance = in_valid && (!in_last || out_space);

    crc16fc_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_byte    (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .i_advance (advance),
        .o_ready   (s_axis_tready),
        .o_valid   (in_valid),
        .o_byte    (in_byte),
        .o_last    (in_last)
    );

    // The frame logic counts bytes, captures the header fields and the length, runs the
    // CRC over the byte three places back and, on the last byte, forms the report.
    crc16fc_frame #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_advance   (advance),
        .i_byte      (in_byte),
        .i_last      (in_last),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    crc16fc_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .i_ready (m_axis_tready),
        .o_space (out_space),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata)
    );

endmodule

// ===== sv/crc16fc_checker.sv =====
// Port-level assertions for the frame checker and the bind that attaches them.
module crc16fc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [crc16fc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // A stalled report keeps its beat.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("report changed while stalled");

    // The bits above the report fields are always zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[crc16fc_pkg::OUT_TDATA_W-1:crc16fc_pkg::RES_W] == '0)
        else $error("report padding not zero");

    // Status is never the unused code.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("report carries an undefined status");

    // Out of reset no report is pending and the input side is open.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not idle after reset");

endmodule

bind crc16_frame_checker_core crc16fc_checker u_crc16fc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the CRC-16/MODBUS frame checker core.
`timescale 1ns / 100ps

module testbench;

    // A report leaves the block from the result register after the beat that closes its frame.
    localparam int REPORT_LATENCY = 2;
    localparam int LEN_MASK       = (1 << crc16fc_pkg::LEN_WIDTH_DEF) - 1;
    // Cycles the receiver refuses reports during the back-pressure test.
    localparam int LONG_STALL     = 300;
    // Random bytes per idling phase.
    localparam int PHASE_BYTES    = 600;

    // Kinds of frames the stimulus builds. Good frames dominate so that the
    // CRC compare is reached often; the others but noise break one rule each.
    typedef enum {
        FK_GOOD,
        FK_BAD_HEADER,
        FK_BAD_TRAILER,
        FK_BAD_LENGTH,
        FK_BAD_CRC,
        FK_TRUNCATED,
        FK_NOISE
    } t_frame_kind;

    // Predicts the report of each frame from the byte beats the block accepts
    // and compares the reports that come out, oldest first.
    class t_report_board;
        logic [7:0]           header_cfg;
        logic [7:0]           trailer_cfg;
        logic [15:0]          count;
        logic [15:0]          crc;
        logic [7:0]           dly [3];
        logic                 hdr_ok;
        logic [7:0]           fields [5];
        logic [15:0]          len_field;
        crc16fc_pkg::t_result expected_reports [$];
        int                   report_errors;

        function new();
            header_cfg    = 8'h00;
            trailer_cfg   = 8'h00;
            report_errors = 0;
            clear_frame();
        endfunction

        // Reflected CRC, data fed least significant bit first.
        static function logic [15:0] crc16_update(logic [15:0] c, logic [7:0] d);
            logic [15:0] r;
            r = c;
            for (int k = 0; k < 8; k++) begin
                if (r[0] ^ d[k]) begin
                    r = (r >> 1) ^ crc16fc_pkg::CRC_POLY;
                end else begin
                    r = r >> 1;
                end
            end
            return r;
        endfunction

        function void clear_frame();
            count     = '0;
            crc       = crc16fc_pkg::CRC_INIT;
            hdr_ok    = 1'b0;
            len_field = '0;
            foreach (dly[i]) dly[i] = '0;
            foreach (fields[i]) fields[i] = '0;
        endfunction

        function void configure(logic index, logic [7:0] value);
            if (index == crc16fc_pkg::CFG_HEADER) begin
                header_cfg = value;
            end else begin
                trailer_cfg = value;
            end
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        // Notes one accepted byte beat; a marked last byte yields a report.
        function void take_byte(logic [7:0] b, logic last);
            int unsigned          pos;
            int unsigned          total;
            logic [15:0]          recv_crc;
            crc16fc_pkg::t_result rpt;
            pos = count;
            if (pos == 0) begin
                hdr_ok = (b == header_cfg);
            end else if (pos <= 5) begin
                fields[pos - 1] = b;
            end else if (pos == 6) begin
                len_field = {b, 8'h00};
            end else if (pos == 7) begin
                len_field[7:0] = b;
            end
            // The oldest delayed byte sits at offset pos-3 and is covered from offset 1 on.
            if (pos >= 4) begin
                crc = crc16_update(crc, dly[2]);
            end
            if (!last) begin
                dly[2] = dly[1];
                dly[1] = dly[0];
                dly[0] = b;
                if (count != LEN_MASK[15:0]) begin
                    count = count + 16'd1;
                end
                return;
            end
            total    = (pos < LEN_MASK) ? pos + 1 : LEN_MASK;
            recv_crc = {dly[0], dly[1]};
            if (total < crc16fc_pkg::FRAME_OVERHEAD || !hdr_ok || b != trailer_cfg) begin
                rpt.status = crc16fc_pkg::ST_FORMAT;
            end else if (total != ((int'(len_field) + crc16fc_pkg::FRAME_OVERHEAD)
                                   & LEN_MASK)) begin
                rpt.status = crc16fc_pkg::ST_FORMAT;
            end else if (crc != recv_crc) begin
                rpt.status = crc16fc_pkg::ST_CRC;
            end else begin
                rpt.status = crc16fc_pkg::ST_OK;
            end
            rpt.dst_addr    = fields[0];
            rpt.src_addr    = fields[1];
            rpt.command     = fields[2];
            rpt.flag_bits   = fields[3];
            rpt.seq_number  = fields[4];
            rpt.payload_len = len_field;
            expected_reports.push_back(rpt);
            clear_frame();
        endfunction

        function void note_error(string msg);
            if (report_errors < 10) begin
                $display("%s", msg);
            end
            report_errors++;
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned seen);
            if (want != seen) begin
                note_error($sformatf("report field %s: expected 0x%0h, got 0x%0h",
                                     field, want, seen));
            end
        endfunction

        // Checks one accepted report beat against the oldest prediction.
        function void check_report(logic [crc16fc_pkg::OUT_TDATA_W-1:0] beat);
            crc16fc_pkg::t_result want;
            crc16fc_pkg::t_result seen;
            if (expected_reports.size() == 0) begin
                note_error($sformatf("report beat 0x%h arrived with none expected", beat));
                return;
            end
            want = expected_reports.pop_front();
            seen = beat[crc16fc_pkg::RES_W-1:0];
            compare_field("status", want.status, seen.status);
            compare_field("dst_addr", want.dst_addr, seen.dst_addr);
            compare_field("src_addr", want.src_addr, seen.src_addr);
            compare_field("command", want.command, seen.command);
            compare_field("flag_bits", want.flag_bits, seen.flag_bits);
            compare_field("seq_number", want.seq_number, seen.seq_number);
            compare_field("payload_len", want.payload_len, seen.payload_len);
            compare_field("padding", 0,
                          beat[crc16fc_pkg::OUT_TDATA_W-1:crc16fc_pkg::RES_W]);
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                i_cfg_we      = 1'b0;
    logic                                i_cfg_index   = crc16fc_pkg::CFG_HEADER;
    logic [7:0]                          i_cfg_data    = 8'h00;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    // tdata: [7:0] frame_byte
    logic [crc16fc_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // tlast: last_byte
    logic                                s_axis_tlast  = 1'b0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    // tdata: [1:0] status, [9:2] dst_addr, [17:10] src_addr, [25:18] command,
    // [33:26] flag_bits, [41:34] seq_number, [57:42] payload_len, [63:58] zero
    logic [crc16fc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    t_report_board sb;

    // Idle rates in percent of cycles, set per phase by the main sequence.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    // The main sequence raises the request count; the receiver honors each once.
    int long_stall_requests = 0;
    int long_stalls_taken   = 0;
    int stall_left          = 0;
    int bytes_sent          = 0;

    // Register values as last written, used to build matching frames.
    logic [7:0] cur_header  = 8'h00;
    logic [7:0] cur_trailer = 8'h00;

    crc16_frame_checker_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver side. Ready changes on the falling edge only. A pending long
    // stall request turns into a counted stretch of refused reports.
    always @(negedge i_clk) begin
        if (long_stall_requests != long_stalls_taken) begin
            stall_left = LONG_STALL;
            long_stalls_taken++;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Report beats are taken at the rising edge, before the block updates.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_report(m_axis_tdata);
        end
    end

    // Writes one configuration register; the block is idle whenever this is called.
    task automatic write_reg(input logic index, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.configure(index, value);
        if (index == crc16fc_pkg::CFG_HEADER) begin
            cur_header = value;
        end else begin
            cur_trailer = value;
        end
    endtask

    // Offers one byte beat, after random idle cycles, and waits for its handshake.
    // Consecutive beats get exactly one assignment per falling edge, so valid
    // simply stays high between them.
    task automatic push_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        sb.take_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame(ref logic [7:0] q[$]);
        for (int i = 0; i < q.size(); i++) begin
            push_byte(q[i], i == q.size() - 1);
        end
    endtask

    // Drops valid, waits for every predicted report, then lets the pipeline settle.
    task automatic wait_for_reports();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (REPORT_LATENCY + 3) @(posedge i_clk);
    endtask

    // Builds one frame for the current header and trailer, then breaks it as
    // the kind asks. But for noise, the CRC is computed over the bytes as sent before
    // the break, so a bad length still carries a valid CRC.
    function automatic void build_frame(input t_frame_kind kind, input int plen,
                                        ref logic [7:0] q[$]);
        logic [15:0] crc;
        logic [15:0] declared_len;
        int          keep;
        q.delete();
        if (kind == FK_NOISE) begin
            keep = $urandom_range(1, 24);
            for (int i = 0; i < keep; i++) q.push_back(8'($urandom_range(255)));
            if ($urandom_range(1)) q[0] = cur_header;
            return;
        end
        declared_len = 16'(plen);
        if (kind == FK_BAD_LENGTH) begin
            declared_len = 16'(plen + $urandom_range(1, LEN_MASK));
        end
        q.push_back(cur_header);
        for (int i = 0; i < crc16fc_pkg::NUM_FIELDS; i++) begin
            q.push_back(8'($urandom_range(255)));
        end
        q.push_back(declared_len[15:8]);
        q.push_back(declared_len[7:0]);
        for (int i = 0; i < plen; i++) q.push_back(8'($urandom_range(255)));
        crc = crc16fc_pkg::CRC_INIT;
        for (int i = 1; i < q.size(); i++) begin
            crc = t_report_board::crc16_update(crc, q[i]);
        end
        q.push_back(crc[7:0]);
        q.push_back(crc[15:8]);
        q.push_back(cur_trailer);
        case (kind)
            FK_BAD_HEADER: begin
                q[0] = q[0] ^ 8'($urandom_range(1, 255));
            end
            FK_BAD_TRAILER: begin
                q[q.size() - 1] = q[q.size() - 1] ^ 8'($urandom_range(1, 255));
            end
            FK_BAD_CRC: begin
                keep = q.size() - $urandom_range(2, 3);
                q[keep] = q[keep] ^ 8'($urandom_range(1, 255));
            end
            FK_TRUNCATED: begin
                keep = $urandom_range(0, q.size() - 2);
                q = q[0:keep];
            end
            default: begin
            end
        endcase
    endfunction

    // Random frames until the phase has sent its share of bytes. Most payloads
    // are short; a few reach a couple of hundred bytes.
    task automatic random_frames(input int byte_budget);
        logic [7:0]  q[$];
        int          start;
        int          pick;
        int          plen;
        t_frame_kind kind;
        start = bytes_sent;
        while (bytes_sent - start < byte_budget) begin
            pick = $urandom_range(99);
            if (pick < 55) kind = FK_GOOD;
            else if (pick < 62) kind = FK_BAD_HEADER;
            else if (pick < 69) kind = FK_BAD_TRAILER;
            else if (pick < 76) kind = FK_BAD_LENGTH;
            else if (pick < 85) kind = FK_BAD_CRC;
            else if (pick < 92) kind = FK_TRUNCATED;
            else kind = FK_NOISE;
            plen = ($urandom_range(99) < 95) ? $urandom_range(0, 12) : $urandom_range(13, 200);
            build_frame(kind, plen, q);
            send_frame(q);
        end
    endtask

    initial begin
        logic [7:0] q[$];
        sb = new();
        // Synchronous reset held low at the start, then released on a falling edge.
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Phase one: sender idles rarely, receiver mostly; header all ones,
        // trailer all zeros.
        tx_idle_pct = 10;
        rx_idle_pct = 84;
        write_reg(crc16fc_pkg::CFG_HEADER, 8'hFF);
        write_reg(crc16fc_pkg::CFG_TRAILER, 8'h00);

        // A single byte that matches the header but makes a frame too short.
        push_byte(8'hFF, 1'b1);
        // Ten zero bytes: one short of the smallest frame, wrong header too.
        // The report carries whatever header fields arrived.
        for (int i = 0; i < 10; i++) push_byte(8'h00, i == 9);
        // A well-formed frame with an empty payload.
        build_frame(FK_GOOD, 0, q);
        send_frame(q);

        random_frames(PHASE_BYTES);
        wait_for_reports();

        // Phase two: idling swapped; header all zeros, trailer all ones.
        tx_idle_pct = 84;
        rx_idle_pct = 10;
        write_reg(crc16fc_pkg::CFG_HEADER, 8'h00);
        write_reg(crc16fc_pkg::CFG_TRAILER, 8'hFF);
        random_frames(PHASE_BYTES);
        wait_for_reports();

        // Phase three: no idling, random register values.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(crc16fc_pkg::CFG_HEADER, 8'($urandom_range(255)));
        write_reg(crc16fc_pkg::CFG_TRAILER, 8'($urandom_range(255)));

        // Back-pressure: the receiver refuses reports for a long stretch while
        // one-byte frames keep coming, so a report waits in the result register and the input stalls.
        // The sender then pauses until every report has drained.
        long_stall_requests++;
        for (int i = 0; i < 20; i++) push_byte(8'($urandom_range(255)), 1'b1);
        wait_for_reports();

        random_frames(PHASE_BYTES);
        wait_for_reports();

        if (sb.report_errors == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
